// ===== sv/rsc_pkg.sv =====
package rsc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_OUT_W = 7;

    typedef logic [3:0] t_kind;
    localparam t_kind KIND_PUSH  = 4'd0;
    localparam t_kind KIND_ADD   = 4'd1;
    localparam t_kind KIND_SUB   = 4'd2;
    localparam t_kind KIND_MUL   = 4'd3;
    localparam t_kind KIND_DIV   = 4'd4;
    localparam t_kind KIND_MOD   = 4'd5;
    localparam t_kind KIND_PRINT = 4'd6;
    localparam t_kind KIND_CLEAR = 4'd7;
    localparam t_kind KIND_DUP   = 4'd8;
    localparam t_kind KIND_SWAP  = 4'd9;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FEW  = 2'd1;
    localparam t_status ST_FULL = 2'd2;
    localparam t_status ST_ZDIV = 2'd3;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] operand;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]     top_value;
        logic                   shown;
        t_status                status;
        logic [DEPTH_OUT_W-1:0] depth_now;
    } t_out_item;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_PUSH,
        CMD_DUP,
        CMD_CLEAR,
        CMD_READ,
        CMD_ARITH,
        CMD_ZDIV,
        CMD_MUL_FIN,
        CMD_DIV_STEP,
        CMD_DIV_FIN,
        CMD_SWAP_FIN
    } t_op;

    typedef struct packed {
        logic    take;
        t_op     op;
        logic    emit;
        t_status status;
        logic    shown;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_lt2;
        logic cnt_full;
        logic div_zero;
        logic div_last;
        logic out_free;
    } t_stat;

    function automatic logic [DEPTH_OUT_W-1:0] to_depth(input logic [CNT_W-1:0] c);
        logic [CNT_W+DEPTH_OUT_W-1:0] t;
        t = {{DEPTH_OUT_W{1'b0}}, c};
        return t[DEPTH_OUT_W-1:0];
    endfunction

endpackage

// ===== sv/rsc_ctrl.sv =====
module rsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rsc_pkg::t_kind i_kind,
    input  rsc_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output rsc_pkg::t_cmd  o_cmd
);
    import rsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_EXEC, S_MULFIN, S_DIV, S_DIVFIN, S_SWAP, S_EMIT
    } t_state;

    t_state  r_state, n_state;
    t_kind   r_kind, n_kind;
    t_status r_status, n_status;
    logic    r_shown, n_shown;
    t_cmd    w_cmd;

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_status = r_status;
        n_shown  = r_shown;
        w_cmd    = '{take: 1'b0, op: CMD_NONE, emit: 1'b0, status: r_status, shown: r_shown};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.take = 1'b1;
                    n_kind     = i_kind;
                    n_status   = ST_OK;
                    n_shown    = 1'b0;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                unique case (r_kind) inside
                    KIND_PUSH: begin
                        if (i_stat.cnt_full) n_status = ST_FULL;
                        else w_cmd.op = CMD_PUSH;
                    end
                    KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MOD, KIND_SWAP: begin
                        if (i_stat.cnt_lt2) begin
                            n_status = ST_FEW;
                        end else begin
                            w_cmd.op = CMD_READ;
                            n_state  = S_EXEC;
                        end
                    end
                    KIND_PRINT: begin
                        if (i_stat.cnt_zero) n_status = ST_FEW;
                        else n_shown = 1'b1;
                    end
                    KIND_CLEAR: w_cmd.op = CMD_CLEAR;
                    KIND_DUP: begin
                        if (i_stat.cnt_zero) n_status = ST_FEW;
                        else if (i_stat.cnt_full) n_status = ST_FULL;
                        else w_cmd.op = CMD_DUP;
                    end
                    default: ;
                endcase
            end
            S_EXEC: begin
                unique case (r_kind) inside
                    KIND_MUL: begin
                        w_cmd.op = CMD_ARITH;
                        n_state  = S_MULFIN;
                    end
                    KIND_DIV, KIND_MOD: begin
                        if (i_stat.div_zero) begin
                            w_cmd.op = CMD_ZDIV;
                            n_status = ST_ZDIV;
                            n_state  = S_EMIT;
                        end else begin
                            w_cmd.op = CMD_ARITH;
                            n_state  = S_DIV;
                        end
                    end
                    KIND_SWAP: begin
                        w_cmd.op = CMD_ARITH;
                        n_state  = S_SWAP;
                    end
                    default: begin
                        w_cmd.op = CMD_ARITH;
                        n_state  = S_EMIT;
                    end
                endcase
            end
            S_MULFIN: begin
                w_cmd.op = CMD_MUL_FIN;
                n_state  = S_EMIT;
            end
            S_DIV: begin
                w_cmd.op = CMD_DIV_STEP;
                if (i_stat.div_last) n_state = S_DIVFIN;
            end
            S_DIVFIN: begin
                w_cmd.op = CMD_DIV_FIN;
                n_state  = S_EMIT;
            end
            S_SWAP: begin
                w_cmd.op = CMD_SWAP_FIN;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    w_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= KIND_PUSH;
            r_status <= ST_OK;
            r_shown  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_status <= n_status;
            r_shown  <= n_shown;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

// ===== sv/rsc_dpath.sv =====
module rsc_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsc_pkg::t_in_item i_in_item,
    input  rsc_pkg::t_cmd     i_cmd,
    output rsc_pkg::t_stat    o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output rsc_pkg::t_out_item o_out_item
);
    import rsc_pkg::*;

    localparam int DIV_STEPS = 48;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    logic [31:0]        r_mem [STACK_DEPTH];
    logic signed [31:0] r_rd_data;
    logic signed [31:0] r_top;
    logic signed [31:0] r_hold;
    logic signed [31:0] r_operand;
    t_kind              r_kind;
    logic [CNT_W-1:0]   r_count, n_count;
    logic signed [63:0] r_prod;
    logic [47:0]        r_quo;
    logic [31:0]        r_rem;
    logic [31:0]        r_dvs;
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_neg;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CNT_W-1:0]   w_cnt_m1, w_cnt_m2;
    logic [ADDR_W-1:0]  w_addr_top, w_addr_sec, w_addr_new;
    logic signed [31:0] w_a, w_b;
    logic [31:0]        w_abs_a, w_abs_b;
    logic signed [32:0] w_sum;
    logic signed [31:0] w_addsub;
    logic signed [47:0] w_msh;
    logic signed [31:0] w_mul;
    logic [32:0]        w_rsh;
    logic               w_ge;
    logic [32:0]        w_rdiff;
    logic signed [31:0] w_dres;
    logic [31:0]        w_modval;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [31:0]        w_wdata;

    function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
        if (x > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (x < -48'sh0000_8000_0000) return -32'sh8000_0000;
        return x[31:0];
    endfunction

    assign w_cnt_m1   = r_count - CNT_W'(1);
    assign w_cnt_m2   = r_count - CNT_W'(2);
    assign w_addr_top = w_cnt_m1[ADDR_W-1:0];
    assign w_addr_sec = w_cnt_m2[ADDR_W-1:0];
    assign w_addr_new = r_count[ADDR_W-1:0];

    assign w_a     = r_rd_data;
    assign w_b     = r_top;
    assign w_abs_a = w_a[31] ? (~w_a + 32'd1) : w_a;
    assign w_abs_b = w_b[31] ? (~w_b + 32'd1) : w_b;

    always_comb begin
        if (r_kind == KIND_SUB) w_sum = {w_a[31], w_a} - {w_b[31], w_b};
        else w_sum = {w_a[31], w_a} + {w_b[31], w_b};
        if (w_sum[32] != w_sum[31]) w_addsub = w_sum[32] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
        else w_addsub = w_sum[31:0];
    end

    // truncate toward zero: arithmetic shift rounds down, fix up negatives
    assign w_msh = r_prod[63:16] + {47'd0, (r_prod[63] && (r_prod[15:0] != 16'd0))};
    assign w_mul = sat48(w_msh);

    assign w_rsh   = {r_rem, r_quo[47]};
    assign w_ge    = (w_rsh >= {1'b0, r_dvs});
    assign w_rdiff = w_rsh - {1'b0, r_dvs};

    assign w_modval = {r_rem[15:0], 16'd0};

    always_comb begin
        if (r_kind == KIND_MOD) begin
            w_dres = r_neg ? -w_modval : w_modval;
        end else if (!r_neg) begin
            w_dres = (r_quo > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : r_quo[31:0];
        end else begin
            w_dres = (r_quo > 48'h0000_8000_0000) ? -32'sh8000_0000 : -r_quo[31:0];
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr_sec;
        w_wdata = w_addsub;
        n_count = r_count;
        case (i_cmd.op)
            CMD_PUSH: begin
                w_we = 1'b1; w_waddr = w_addr_new; w_wdata = r_operand;
                n_count = r_count + CNT_W'(1);
            end
            CMD_DUP: begin
                w_we = 1'b1; w_waddr = w_addr_new; w_wdata = r_top;
                n_count = r_count + CNT_W'(1);
            end
            CMD_CLEAR: n_count = '0;
            CMD_ARITH: begin
                if (r_kind == KIND_ADD || r_kind == KIND_SUB) begin
                    w_we = 1'b1; n_count = w_cnt_m1;
                end else if (r_kind == KIND_SWAP) begin
                    w_we = 1'b1; w_waddr = w_addr_top; w_wdata = w_a;
                end
            end
            CMD_ZDIV: n_count = w_cnt_m1;
            CMD_MUL_FIN: begin
                w_we = 1'b1; w_wdata = w_mul; n_count = w_cnt_m1;
            end
            CMD_DIV_FIN: begin
                w_we = 1'b1; w_wdata = w_dres; n_count = w_cnt_m1;
            end
            CMD_SWAP_FIN: begin
                w_we = 1'b1; w_wdata = r_top;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (i_cmd.op == CMD_READ) r_rd_data <= r_mem[w_addr_sec];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind    <= i_in_item.kind;
            r_operand <= i_in_item.operand;
        end
        case (i_cmd.op)
            CMD_PUSH: r_top <= r_operand;
            CMD_ARITH: begin
                if (r_kind == KIND_ADD || r_kind == KIND_SUB) begin
                    r_top <= w_addsub;
                end else if (r_kind == KIND_MUL) begin
                    r_prod <= w_a * w_b;
                end else if (r_kind == KIND_SWAP) begin
                    r_hold <= w_a;
                end else if (r_kind == KIND_MOD) begin
                    r_quo  <= {32'd0, w_abs_a[31:16]};
                    r_dvs  <= {16'd0, w_abs_b[31:16]};
                    r_rem  <= '0;
                    r_neg  <= w_a[31];
                    r_dcnt <= '0;
                end else begin
                    r_quo  <= {w_abs_a, 16'd0};
                    r_dvs  <= w_abs_b;
                    r_rem  <= '0;
                    r_neg  <= w_a[31] ^ w_b[31];
                    r_dcnt <= '0;
                end
            end
            CMD_ZDIV: r_top <= w_a;
            CMD_MUL_FIN: r_top <= w_mul;
            CMD_DIV_STEP: begin
                r_quo  <= {r_quo[46:0], w_ge};
                r_rem  <= w_ge ? w_rdiff[31:0] : w_rsh[31:0];
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            CMD_DIV_FIN: r_top <= w_dres;
            CMD_SWAP_FIN: r_top <= r_hold;
            default: ;
        endcase
        if (i_cmd.emit) begin
            r_out.top_value <= (r_count == '0) ? 32'sd0 : r_top;
            r_out.shown     <= i_cmd.shown;
            r_out.status    <= i_cmd.status;
            r_out.depth_now <= to_depth(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.cnt_lt2  = (r_count < CNT_W'(2));
    assign o_stat.cnt_full = (r_count >= CNT_W'(STACK_DEPTH));
    // mod tests the integer part of the divisor, truncated toward zero
    assign o_stat.div_zero = (r_kind == KIND_DIV) ? (w_b == 32'sd0) :
                             ((w_b[31:16] == 16'h0000) ||
                              (w_b[31:16] == 16'hFFFF && w_b[15:0] != 16'd0));
    assign o_stat.div_last = (r_dcnt == DCNT_W'(DIV_STEPS - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== sv/rpn_stack_calculator_unit.sv =====
// Reverse Polish calculator on a 64-entry stack of signed Q16.16 values, one token per
// item and one result item per token. Items are taken one at a time; the next is not
// accepted until the result of the last has been handed to the output register. Div and
// mod run the 48-step restoring divider, and an error on the divisor skips it. The stack
// lives in a single-port-write memory with a registered read, and the top entry is also
// held in a register.
module rpn_stack_calculator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rsc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rsc_pkg::t_out_item o_out_item
);
    import rsc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_item.kind),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    rsc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sv/rsc_checker.sv =====
module rsc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input rsc_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input rsc_pkg::t_out_item o_out_item
);
    import rsc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in work");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.depth_now <= DEPTH_OUT_W'(STACK_DEPTH))
        else $error("depth beyond stack size");

    a_shown_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.shown |->
            o_out_item.status == ST_OK && o_out_item.depth_now != '0)
        else $error("print shown with error or empty stack");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.depth_now == '0 |-> o_out_item.top_value == 32'sd0)
        else $error("empty stack with nonzero top");

endmodule

bind rpn_stack_calculator_unit rsc_checker u_chk (.*);

// ===== verif/tb_rpn_stack_calculator_unit.sv =====
module tb_rpn_stack_calculator_unit;
    import rsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    rpn_stack_calculator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // predictor state
    logic [31:0] calc_stack [STACK_DEPTH];
    int          calc_depth;
    t_out_item   expected_results [$];

    int  error_count;
    int  mismatch_count;
    int  items_sent;
    int  results_seen;
    int  idle_cycles;
    int  hold_off_cycles;
    bit  no_gaps;
    bit  timed_out;
    int  status_hits [4];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] clamp_q16(input longint x);
        if (x > 64'sd2147483647) return 32'h7fff_ffff;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic t_out_item predict_token(input t_in_item item);
        t_out_item r;
        t_status   st;
        logic      shw;
        longint    a, b, res, ia, ib;
        logic [31:0] t;
        bit        zero;
        st   = ST_OK;
        shw  = 1'b0;
        zero = 0;
        res  = 0;
        if (item.kind >= KIND_ADD && item.kind <= KIND_MOD) begin
            if (calc_depth < 2) begin
                st = ST_FEW;
            end else begin
                b = longint'($signed(calc_stack[calc_depth-1]));
                a = longint'($signed(calc_stack[calc_depth-2]));
                case (item.kind)
                    KIND_ADD: res = a + b;
                    KIND_SUB: res = a - b;
                    KIND_MUL: res = (a * b) / 65536;
                    KIND_DIV: begin
                        if (b == 0) zero = 1;
                        else res = (a * 65536) / b;
                    end
                    default: begin
                        ia = a / 65536;
                        ib = b / 65536;
                        if (ib == 0) zero = 1;
                        else res = (ia % ib) * 65536;
                    end
                endcase
                if (zero) begin
                    st = ST_ZDIV;
                end else begin
                    calc_stack[calc_depth-2] = clamp_q16(res);
                end
                calc_depth--;
            end
        end else if (item.kind == KIND_PUSH) begin
            if (calc_depth >= STACK_DEPTH) st = ST_FULL;
            else calc_stack[calc_depth++] = item.operand;
        end else if (item.kind == KIND_PRINT) begin
            if (calc_depth == 0) st = ST_FEW;
            else shw = 1'b1;
        end else if (item.kind == KIND_CLEAR) begin
            calc_depth = 0;
        end else if (item.kind == KIND_DUP) begin
            if (calc_depth == 0) st = ST_FEW;
            else if (calc_depth >= STACK_DEPTH) st = ST_FULL;
            else begin
                calc_stack[calc_depth] = calc_stack[calc_depth-1];
                calc_depth++;
            end
        end else if (item.kind == KIND_SWAP) begin
            if (calc_depth < 2) st = ST_FEW;
            else begin
                t = calc_stack[calc_depth-1];
                calc_stack[calc_depth-1] = calc_stack[calc_depth-2];
                calc_stack[calc_depth-2] = t;
            end
        end
        r.top_value = (calc_depth == 0) ? 32'sd0 : calc_stack[calc_depth-1];
        r.shown     = shw;
        r.status    = st;
        r.depth_now = calc_depth[DEPTH_OUT_W-1:0];
        return r;
    endfunction

    // valid stays high between back-to-back items and drops only for a gap
    task automatic send_token(input t_kind kind, input logic [31:0] operand);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item  <= '{kind: kind, operand: operand};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(predict_token('{kind: kind, operand: operand}));
        status_hits[expected_results[$].status]++;
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0 && !timed_out) @(posedge i_clk);
    endtask

    // result checker and receiver backpressure
    initial begin
        int stall;
        t_out_item exp_item;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 17);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid && hold_off_cycles == 0);
            if (o_out_valid) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("unexpected result item %h", o_out_item);
                end else begin
                    exp_item = expected_results.pop_front();
                    if (o_out_item !== exp_item) begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected top=%h shown=%b st=%0d depth=%0d,",
                                      " got top=%h shown=%b st=%0d depth=%0d"},
                                     exp_item.top_value, exp_item.shown, exp_item.status,
                                     exp_item.depth_now, o_out_item.top_value,
                                     o_out_item.shown, o_out_item.status,
                                     o_out_item.depth_now);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [31:0] random_q16();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) << 16;
            1: return -($urandom_range(1, 20) << 16);
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            3: return $urandom_range(0, 3) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_token(KIND_ADD, 0);
        send_token(KIND_PRINT, 0);
        send_token(KIND_DUP, 0);
        send_token(KIND_SWAP, 0);
        send_token(KIND_PUSH, 32'h7fff_ffff);
        send_token(KIND_PUSH, 32'h7fff_ffff);
        send_token(KIND_ADD, 0);
        send_token(KIND_PUSH, 32'h8000_0000);
        send_token(KIND_MUL, 0);
        send_token(KIND_PUSH, 32'h0000_0000);
        send_token(KIND_DIV, 0);
        send_token(KIND_PUSH, 32'h0000_8000);
        send_token(KIND_MOD, 0);
        send_token(KIND_PUSH, 32'hfff9_0000);
        send_token(KIND_PUSH, 32'h0002_8000);
        send_token(KIND_SWAP, 0);
        send_token(KIND_MOD, 0);
        send_token(KIND_PUSH, 32'h0003_0000);
        send_token(KIND_DIV, 0);
        send_token(KIND_SUB, 0);
        send_token(KIND_PRINT, 0);
        send_token(t_kind'(4'd15), 32'hffff_ffff);
        send_token(t_kind'(4'd10), 0);
        send_token(KIND_CLEAR, 0);
        wait_drained();
    endtask

    task automatic test_stack_full();
        repeat (STACK_DEPTH) send_token(KIND_PUSH, $urandom);
        send_token(KIND_PUSH, 1);
        send_token(KIND_DUP, 0);
        send_token(KIND_SWAP, 0);
        send_token(KIND_PRINT, 0);
        repeat (STACK_DEPTH - 1) send_token(KIND_ADD, 0);
        send_token(KIND_CLEAR, 0);
    endtask

    // receiver holds off so the sender stalls behind the held result, then sender waits for drain
    task automatic test_backpressure();
        hold_off_cycles = 300;
        repeat (12) send_token(KIND_PUSH, random_q16());
        wait_drained();
        repeat (12) send_token(t_kind'($urandom_range(1, 9)), random_q16());
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int n;
        t_kind k;
        n = 0;
        while (n < count) begin
            if ((n % 200) < 40) no_gaps = 1;
            else no_gaps = 0;
            if (calc_depth < 2 && $urandom_range(0, 3) != 0) k = KIND_PUSH;
            else if ($urandom_range(0, 60) == 0) k = KIND_CLEAR;
            else if ($urandom_range(0, 40) == 0) k = t_kind'($urandom_range(10, 15));
            else k = t_kind'($urandom_range(0, 9));
            send_token(k, random_q16());
            n++;
        end
        no_gaps = 0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_item       = '0;
        calc_depth      = 0;
        error_count     = 0;
        mismatch_count  = 0;
        items_sent      = 0;
        results_seen    = 0;
        idle_cycles     = 0;
        hold_off_cycles = 0;
        no_gaps         = 0;
        timed_out       = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_stack_full();
        test_backpressure();
        test_random(1250);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d tokens, checked %0d results", items_sent, results_seen);
        $display("status counts ok=%0d few=%0d full=%0d zdiv=%0d", status_hits[0],
                 status_hits[1], status_hits[2], status_hits[3]);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d errors, %0d results missing", error_count, expected_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
